@@ rtl/variable_partition_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Variable partition allocator assertion macros
// Checks that tie to the local clock and reset; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define VPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define VPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VPA_ASSERT(lbl, prop, msg)
`define VPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/vpa_pkg.sv @@
// ----------------------------------------------------------------------------
// vpa_pkg
// Types, codes and sizes shared by the segment allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int UNITS_W      = 17;
    localparam int OWNER_W      = 8;
    localparam int CFG_IDX_W    = 8;
    localparam logic [UNITS_W-1:0] UNITS_LIMIT = 17'd65536;
    localparam logic [UNITS_W-1:0] UNITS_RESET = 17'd4000;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NO_OWN  = 2'd3;

    // policy codes
    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS  = 8'd1;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [UNITS_W-1:0]   units;
        logic                 free;
        logic [OWNER_W-1:0]   owner;
    } t_seg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_seg             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_POST,
        S_UP_RD,
        S_UP_WR,
        S_WR_REM,
        S_WR_PICK,
        S_FR_RDN,
        S_FR_MRG,
        S_DN_RD,
        S_DN_WR
    } t_state;

endpackage

`default_nettype wire

@@ rtl/variable_partition_allocator.sv @@
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First / best / worst fit segment allocator over an address-ordered table.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// request   start & !busy               i_kind, i_owner_id, i_request_units
// result    o_valid (one cycle)         o_status, o_base_address, o_segment_units
// config    i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item scans the table one entry per cycle through the table memory's
// read port. A split then moves each entry after the pick up by one, with a
// read and a write each, then writes the remainder and the pick; a free
// reads both neighbors, writes the hole, and shifts entries down on a merge.
// Reset, and any write of memory_units, reforms entry 0.
// Results cannot be stalled; o_valid pulses for one cycle per item.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_partition_allocator
    import vpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_kind,
    input  wire logic [OWNER_W-1:0]   i_owner_id,
    input  wire logic [UNITS_W-1:0]   i_request_units,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [ADDR_BITS-1:0]      o_base_address,
    output logic [UNITS_W-1:0]        o_segment_units,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [UNITS_W-1:0]   i_cfg_data
);

`include "variable_partition_allocator_defines.svh"

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [UNITS_W-1:0]   r_mem_units, n_mem_units;
    logic [1:0]           r_policy, n_policy;
    logic                 r_kind, n_kind;
    logic [OWNER_W-1:0]   r_owner, n_owner;
    logic [UNITS_W-1:0]   r_req, n_req;
    logic [CNT_W-1:0]     r_iss, n_iss;
    logic                 r_dv, n_dv;
    logic [IDX_W-1:0]     r_didx, n_didx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [ADDR_BITS-1:0] r_pstart, n_pstart;
    logic [UNITS_W-1:0]   r_punits, n_punits;
    logic [CNT_W-1:0]     r_k, n_k;
    t_seg                 r_prev, n_prev;
    logic                 r_pf, n_pf;
    logic [1:0]           r_d, n_d;
    logic                 r_out_v, n_out_v;
    logic [1:0]           r_out_status, n_out_status;
    logic [ADDR_BITS-1:0] r_out_base, n_out_base;
    logic [UNITS_W-1:0]   r_out_units, n_out_units;

    t_mem_req mem_req;
    t_seg     rd;

    logic alloc_fit, better, free_hit, early, hit, nf;
    logic [UNITS_W-1:0] msum;
    logic [CNT_W-1:0]   pick_up;

    vpa_seg_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_mem_units <= UNITS_RESET;
            r_policy    <= POL_FIRST;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mem_units <= n_mem_units;
            r_policy    <= n_policy;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_out_v     <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_owner      <= n_owner;
        r_req        <= n_req;
        r_iss        <= n_iss;
        r_didx       <= n_didx;
        r_pick       <= n_pick;
        r_pstart     <= n_pstart;
        r_punits     <= n_punits;
        r_k          <= n_k;
        r_prev       <= n_prev;
        r_pf         <= n_pf;
        r_d          <= n_d;
        r_out_status <= n_out_status;
        r_out_base   <= n_out_base;
        r_out_units  <= n_out_units;
    end

    always_comb begin
        alloc_fit = rd.free && (rd.units >= r_req) && (r_req != '0);
        better    = !r_found
                  || ((r_policy == POL_BEST) && (rd.units < r_punits))
                  || ((r_policy == POL_WORST) && (rd.units > r_punits));
        free_hit  = !rd.free && (rd.owner == r_owner);
        early     = (r_kind == KIND_FREE)
                  || ((r_policy != POL_BEST) && (r_policy != POL_WORST));
        hit       = r_dv && ((r_kind == KIND_FREE) ? free_hit : (alloc_fit && better));
        pick_up   = CNT_W'(r_pick) + CNT_W'(1);
        nf        = (pick_up < r_count) && rd.free;
        msum      = (r_pf ? r_prev.units : '0) + r_punits + (nf ? rd.units : '0);
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mem_units  = r_mem_units;
        n_policy     = r_policy;
        n_kind       = r_kind;
        n_owner      = r_owner;
        n_req        = r_req;
        n_iss        = r_iss;
        n_dv         = 1'b0;
        n_didx       = r_didx;
        n_found      = r_found;
        n_pick       = r_pick;
        n_pstart     = r_pstart;
        n_punits     = r_punits;
        n_k          = r_k;
        n_prev       = r_prev;
        n_pf         = r_pf;
        n_d          = r_d;
        n_out_v      = 1'b0;
        n_out_status = r_out_status;
        n_out_base   = r_out_base;
        n_out_units  = r_out_units;
        mem_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_owner = i_owner_id;
                    n_req   = i_request_units;
                    n_iss   = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_INIT: begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = '0;
                mem_req.wdata.start = '0;
                mem_req.wdata.units = r_mem_units;
                mem_req.wdata.free  = 1'b1;
                mem_req.wdata.owner = '0;
                n_count = (r_mem_units == '0) ? '0 : CNT_W'(1);
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (hit) begin
                    n_found  = 1'b1;
                    n_pick   = r_didx;
                    n_pstart = rd.start;
                    n_punits = rd.units;
                end
                if (hit && early) begin
                    n_state = S_POST;
                end else if (!r_dv && (r_iss == r_count)) begin
                    n_state = S_POST;
                end else if (r_iss < r_count) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_iss[IDX_W-1:0];
                    n_iss  = r_iss + CNT_W'(1);
                    n_dv   = 1'b1;
                    n_didx = r_iss[IDX_W-1:0];
                end
            end
            S_POST: begin
                if (r_kind == KIND_ALLOC) begin
                    if (!r_found) begin
                        n_out_v      = 1'b1;
                        n_out_status = ST_NO_FIT;
                        n_out_base   = '0;
                        n_out_units  = '0;
                        n_state      = S_IDLE;
                    end else if (r_punits == r_req) begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = r_pick;
                        mem_req.wdata.start = r_pstart;
                        mem_req.wdata.units = r_punits;
                        mem_req.wdata.free  = 1'b0;
                        mem_req.wdata.owner = r_owner;
                        n_out_v      = 1'b1;
                        n_out_status = ST_OK;
                        n_out_base   = r_pstart;
                        n_out_units  = r_punits;
                        n_state      = S_IDLE;
                    end else if (r_count == CNT_W'(MAX_SEGMENTS)) begin
                        n_out_v      = 1'b1;
                        n_out_status = ST_FULL;
                        n_out_base   = '0;
                        n_out_units  = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_k     = r_count;
                        n_state = S_UP_RD;
                    end
                end else begin
                    if (!r_found) begin
                        n_out_v      = 1'b1;
                        n_out_status = ST_NO_OWN;
                        n_out_base   = '0;
                        n_out_units  = '0;
                        n_state      = S_IDLE;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_pick - IDX_W'(1);
                        n_state = S_FR_RDN;
                    end
                end
            end
            // move entries up by one to open the slot after the pick
            S_UP_RD: begin
                if (r_k > pick_up) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(r_k - CNT_W'(1));
                    n_state = S_UP_WR;
                end else begin
                    n_state = S_WR_REM;
                end
            end
            S_UP_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_k[IDX_W-1:0];
                mem_req.wdata = rd;
                n_k     = r_k - CNT_W'(1);
                n_state = S_UP_RD;
            end
            S_WR_REM: begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = r_pick + IDX_W'(1);
                mem_req.wdata.start = r_pstart + r_req[ADDR_BITS-1:0];
                mem_req.wdata.units = r_punits - r_req;
                mem_req.wdata.free  = 1'b1;
                mem_req.wdata.owner = '0;
                n_state = S_WR_PICK;
            end
            S_WR_PICK: begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = r_pick;
                mem_req.wdata.start = r_pstart;
                mem_req.wdata.units = r_req;
                mem_req.wdata.free  = 1'b0;
                mem_req.wdata.owner = r_owner;
                n_count      = r_count + CNT_W'(1);
                n_out_v      = 1'b1;
                n_out_status = ST_OK;
                n_out_base   = r_pstart;
                n_out_units  = r_req;
                n_state      = S_IDLE;
            end
            S_FR_RDN: begin
                n_prev        = rd;
                n_pf          = (r_pick != '0) && rd.free;
                mem_req.re    = 1'b1;
                mem_req.raddr = r_pick + IDX_W'(1);
                n_state = S_FR_MRG;
            end
            // the table never holds two neighboring holes, so a merge only
            // involves the freed entry and its two neighbors
            S_FR_MRG: begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = r_pick - (r_pf ? IDX_W'(1) : '0);
                mem_req.wdata.start = r_pf ? r_prev.start : r_pstart;
                mem_req.wdata.units = msum;
                mem_req.wdata.free  = 1'b1;
                mem_req.wdata.owner = '0;
                n_d     = {1'b0, r_pf} + {1'b0, nf};
                n_k     = pick_up + (nf ? CNT_W'(1) : '0);
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if ((r_d != '0) && (r_k < r_count)) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_k[IDX_W-1:0];
                    n_state = S_DN_WR;
                end else begin
                    n_count      = r_count - CNT_W'(r_d);
                    n_out_v      = 1'b1;
                    n_out_status = ST_OK;
                    n_out_base   = r_pstart;
                    n_out_units  = r_punits;
                    n_state      = S_IDLE;
                end
            end
            S_DN_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(r_k - CNT_W'(r_d));
                mem_req.wdata = rd;
                n_k     = r_k + CNT_W'(1);
                n_state = S_DN_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the user must send configuration only while idle; the block does not enforce it
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLICY: n_policy = i_cfg_data[1:0];
                CFG_UNITS: begin
                    n_mem_units = (i_cfg_data > UNITS_LIMIT) ? UNITS_LIMIT : i_cfg_data;
                    n_state     = S_INIT;
                end
                default: ;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_v;
    assign o_status        = r_out_status;
    assign o_base_address  = r_out_base;
    assign o_segment_units = r_out_units;

    `VPA_ASSERT(a_strobe_one, r_out_v |=> !r_out_v, "result strobe held")
    `VPA_ASSERT(a_count_max, r_count <= CNT_W'(MAX_SEGMENTS), "segment count overflow")
    `VPA_ASSERT(a_take_busy, (start && !busy) |=> busy, "accepted item left block idle")
    `VPA_ASSERT(a_result_idle, r_out_v |-> (r_state == S_IDLE || r_state == S_INIT),
                "result while working")

endmodule

`default_nettype wire

@@ rtl/vpa_seg_mem.sv @@
// ----------------------------------------------------------------------------
// vpa_seg_mem
// Segment table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_seg_mem
    import vpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_seg          o_rd_data
);

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire
